// File: hw/rtl/tmprof_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoidal move profile package
// Shared widths, register indexes, reset values and payload types.
// ----------------------------------------------------------------------------
package tmprof_pkg;

    localparam int VALUE_WIDTH       = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int TICK_BITS         = 16;
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PER = 2'd2;

    localparam logic [VALUE_WIDTH-2:0] RST_MAX_VEL  = (VALUE_WIDTH-1)'(65536);
    localparam logic [VALUE_WIDTH-2:0] RST_MAX_ACC  = (VALUE_WIDTH-1)'(65536);
    localparam logic [TICK_BITS-1:0]   RST_TICK_PER = TICK_BITS'(66);

    localparam logic OP_SET_TARGET = 1'b0;
    localparam logic OP_TICK       = 1'b1;

    typedef struct packed {
        logic                          operation;
        logic signed [VALUE_WIDTH-1:0] target_distance;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] position;
        logic signed [VALUE_WIDTH-1:0] velocity;
        logic                          done_res;
    } t_out_item;

endpackage

// File: hw/rtl/trapezoidal_move_profile.sv
// ----------------------------------------------------------------------------
// Trapezoidal move profile generator
// Plans a trapezoidal or triangular move from a signed target and steps
// position and velocity one tick period per tick request, Q16.16.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall    | operation, target
//  out     | output    | o_out_valid / i_out_stall  | position, velocity, done
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | index, data
//
//  The divide / root unit takes XW-bit operands (XW = larger of
//  2*VALUE_WIDTH and VALUE_WIDTH+2*FRACTION_BITS, rounded up to even).
//    set-target, trapezoid: ramp divide, vmax^2 divide, cruise divide
//    set-target, triangle:  ramp, vmax^2 and distance divides, then the root
//  Tick request: steps through the shared multiplier; once finished, a tick
//  goes straight to the output.
//  Reset is synchronous, active low; config returns to its reset values.
//  o_in_stall is high while a request is in flight; a finished result waits
//  in the output register while the next request is taken.
//
module trapezoidal_move_profile #(
    parameter int FRACTION_BITS = tmprof_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  tmprof_pkg::t_in_item                 i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output tmprof_pkg::t_out_item                o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tmprof_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tmprof_pkg::VALUE_WIDTH-1:0]   i_cfg_data
);
    localparam int W   = tmprof_pkg::VALUE_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int TB  = tmprof_pkg::TICK_BITS;
    localparam int X1  = 2*W;
    localparam int X2  = W + 2*F;
    localparam int XM  = (X1 > X2) ? X1 : X2;
    localparam int XW  = XM + (XM % 2);
    localparam int MBW = (W > 2*TB) ? W : 2*TB;
    localparam int PW  = W + MBW;

    localparam logic [W-1:0] MAG_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] TIME_MAX = {W{1'b1}};

    // sequencer codes
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_SQV     = 5'd1;
    localparam logic [4:0] ST_RAMP_GO = 5'd2;
    localparam logic [4:0] ST_RAMP_WT = 5'd3;
    localparam logic [4:0] ST_SACC_GO = 5'd4;
    localparam logic [4:0] ST_SACC_WT = 5'd5;
    localparam logic [4:0] ST_CMP     = 5'd6;
    localparam logic [4:0] ST_CRU_GO  = 5'd7;
    localparam logic [4:0] ST_CRU_WT  = 5'd8;
    localparam logic [4:0] ST_Q_GO    = 5'd9;
    localparam logic [4:0] ST_Q_WT    = 5'd10;
    localparam logic [4:0] ST_SQ_GO   = 5'd11;
    localparam logic [4:0] ST_SQ_WT   = 5'd12;
    localparam logic [4:0] ST_PEAK    = 5'd13;
    localparam logic [4:0] ST_PEAK2   = 5'd14;
    localparam logic [4:0] ST_TK0     = 5'd15;
    localparam logic [4:0] ST_TK1     = 5'd16;
    localparam logic [4:0] ST_TK2     = 5'd17;
    localparam logic [4:0] ST_TK3     = 5'd18;
    localparam logic [4:0] ST_TK4     = 5'd19;
    localparam logic [4:0] ST_TK5     = 5'd20;
    localparam logic [4:0] ST_OUT     = 5'd21;

    logic [4:0] r_state, n_state;

    // config registers
    logic [W-2:0]  r_vm, r_am;
    logic [TB-1:0] r_dt;

    // move state, magnitudes
    logic [W-1:0] r_trav, r_speed, r_elapsed, r_ramp, r_cruise, r_peak, r_goal;
    logic         r_fin, r_rev;

    // scratch
    logic [W-1:0]    r_sacc, r_dv, r_acc;
    logic [2*TB-1:0] r_dtsq;
    logic [PW-1:0]   r_prod;

    logic                  r_ov;
    tmprof_pkg::t_out_item r_out;

    // nonzero versions of the limits
    logic [W-2:0] w_vm, w_am;
    assign w_vm = (r_vm == '0) ? (W-1)'(1) : r_vm;
    assign w_am = (r_am == '0) ? (W-1)'(1) : r_am;

    // tick phase from the elapsed time
    logic w_ph_acc, w_ph_cru;
    assign w_ph_acc = r_elapsed < r_ramp;
    assign w_ph_cru = !w_ph_acc &&
                      ({1'b0, r_elapsed} < ({1'b0, r_ramp} + {1'b0, r_cruise}));

    // shared multiplier, registered every cycle
    logic [W-1:0]   w_ma;
    logic [MBW-1:0] w_mb;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_SQV: begin
                w_ma = W'(w_vm);
                w_mb = MBW'(w_vm);
            end
            ST_PEAK: begin
                w_ma = W'(w_am);
                w_mb = MBW'(r_ramp);
            end
            ST_TK0: begin
                w_ma = W'(r_dt);
                w_mb = MBW'(r_dt);
            end
            ST_TK1: begin
                w_ma = W'(w_am);
                w_mb = MBW'(r_dt);
            end
            ST_TK2: begin
                w_ma = W'(w_am);
                w_mb = MBW'(r_dtsq);
            end
            ST_TK3: begin
                w_ma = w_ph_cru ? r_peak : r_speed;
                w_mb = MBW'(r_dt);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_ma) * PW'(w_mb);
    end

    // divide / root unit
    logic          w_it_start, w_it_sqrt, w_it_done;
    logic [XW-1:0] w_it_a, w_it_res;
    logic [W-1:0]  w_it_b;

    always_comb begin
        w_it_start = 1'b0;
        w_it_sqrt  = 1'b0;
        w_it_a     = '0;
        w_it_b     = '0;
        unique case (r_state)
            ST_RAMP_GO: begin
                w_it_start = 1'b1;
                w_it_a     = XW'(w_vm) << F;
                w_it_b     = W'(w_am);
            end
            ST_SACC_GO: begin
                // vmax^2 was latched by the multiplier in the cycle before
                w_it_start = 1'b1;
                w_it_a     = XW'(r_prod);
                w_it_b     = {w_am, 1'b0};
            end
            ST_CRU_GO: begin
                w_it_start = 1'b1;
                w_it_a     = XW'(r_goal - {r_sacc[W-2:0], 1'b0}) << F;
                w_it_b     = W'(w_vm);
            end
            ST_Q_GO: begin
                w_it_start = 1'b1;
                w_it_a     = XW'(r_goal) << F;
                w_it_b     = W'(w_am);
            end
            ST_SQ_GO: begin
                w_it_start = 1'b1;
                w_it_sqrt  = 1'b1;
                w_it_a     = w_it_res << F;
            end
            default: begin
                w_it_start = 1'b0;
            end
        endcase
    end

    tmprof_iter #(
        .OPW(XW),
        .DVW(W)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_it_start),
        .i_sqrt  (w_it_sqrt),
        .i_opa   (w_it_a),
        .i_opb   (w_it_b),
        .o_done  (w_it_done),
        .o_result(w_it_res)
    );

    logic [W-1:0] w_res_time, w_res_mag;
    assign w_res_time = (|w_it_res[XW-1:W]) ? TIME_MAX : w_it_res[W-1:0];
    assign w_res_mag  = (w_it_res > XW'(MAG_MAX)) ? MAG_MAX : w_it_res[W-1:0];

    // target magnitude
    logic [W-1:0] w_raw, w_neg, w_mag;
    assign w_raw = i_in_data.target_distance;
    assign w_neg = -w_raw;
    assign w_mag = w_raw[W-1] ? ((w_neg > MAG_MAX) ? MAG_MAX : w_neg) : w_raw;

    // tick arithmetic
    logic [W-1:0] w_ds, w_peak_cand;
    logic [W+1:0] w_acc_sum, w_tlim;
    logic [W:0]   w_cru_sum, w_spd_sum;
    assign w_ds        = W'(r_prod >> TB);
    assign w_acc_sum   = {2'b00, r_trav} + {2'b00, w_ds} + {2'b00, r_acc};
    assign w_cru_sum   = {1'b0, r_trav} + {1'b0, w_ds};
    assign w_spd_sum   = {1'b0, r_speed} + {1'b0, r_dv};
    assign w_tlim      = {1'b0, r_ramp, 1'b0} + {2'b00, r_cruise};
    assign w_peak_cand = W'(r_prod >> F);

    logic         w_end;
    logic [W-1:0] w_base;
    logic [W:0]   w_el_sum;
    assign w_end    = (r_trav >= r_goal) || ({2'b00, r_elapsed} > w_tlim);
    assign w_base   = w_end ? '0 : r_elapsed;
    assign w_el_sum = {1'b0, w_base} + (W+1)'(r_dt);

    // config port: ready only while idle, so writes never land mid-request
    assign o_cfg_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= tmprof_pkg::RST_MAX_VEL;
            r_am <= tmprof_pkg::RST_MAX_ACC;
            r_dt <= tmprof_pkg::RST_TICK_PER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tmprof_pkg::CFG_MAX_VEL:  r_vm <= i_cfg_data[W-2:0];
                tmprof_pkg::CFG_MAX_ACC:  r_am <= i_cfg_data[W-2:0];
                tmprof_pkg::CFG_TICK_PER: r_dt <= i_cfg_data[TB-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    logic w_take;
    assign w_take = i_in_valid && (r_state == ST_IDLE);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    if (i_in_data.operation == tmprof_pkg::OP_SET_TARGET) n_state = ST_RAMP_GO;
                    else if (r_fin) n_state = ST_OUT;
                    else n_state = ST_TK0;
                end
            end
            ST_RAMP_GO: n_state = ST_RAMP_WT;
            ST_RAMP_WT: if (w_it_done) n_state = ST_SQV;
            ST_SQV:     n_state = ST_SACC_GO;
            ST_SACC_GO: n_state = ST_SACC_WT;
            ST_SACC_WT: if (w_it_done) n_state = ST_CMP;
            ST_CMP: begin
                if ({1'b0, r_goal} > {r_sacc, 1'b0}) n_state = ST_CRU_GO;
                else n_state = ST_Q_GO;
            end
            ST_CRU_GO:  n_state = ST_CRU_WT;
            ST_CRU_WT:  if (w_it_done) n_state = ST_OUT;
            ST_Q_GO:    n_state = ST_Q_WT;
            ST_Q_WT:    if (w_it_done) n_state = ST_SQ_GO;
            ST_SQ_GO:   n_state = ST_SQ_WT;
            ST_SQ_WT:   if (w_it_done) n_state = ST_PEAK;
            ST_PEAK:    n_state = ST_PEAK2;
            ST_PEAK2:   n_state = ST_OUT;
            ST_TK0:     n_state = ST_TK1;
            ST_TK1:     n_state = ST_TK2;
            ST_TK2:     n_state = ST_TK3;
            ST_TK3:     n_state = ST_TK4;
            ST_TK4:     n_state = ST_TK5;
            ST_TK5:     n_state = ST_OUT;
            ST_OUT:     if (!r_ov || !i_out_stall) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_trav    <= '0;
            r_speed   <= '0;
            r_elapsed <= '0;
            r_ramp    <= '0;
            r_cruise  <= '0;
            r_peak    <= '0;
            r_goal    <= '0;
            r_fin     <= 1'b0;
            r_rev     <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_take && i_in_data.operation == tmprof_pkg::OP_SET_TARGET) begin
                        r_rev     <= w_raw[W-1];
                        r_goal    <= w_mag;
                        r_trav    <= '0;
                        r_speed   <= '0;
                        r_elapsed <= '0;
                        r_fin     <= 1'b0;
                    end
                end
                ST_RAMP_WT: if (w_it_done) r_ramp <= w_res_time;
                ST_CMP: begin
                    if ({1'b0, r_goal} > {r_sacc, 1'b0}) r_peak <= W'(w_vm);
                    else r_cruise <= '0;
                end
                ST_CRU_WT: if (w_it_done) r_cruise <= w_res_time;
                ST_SQ_WT:  if (w_it_done) r_ramp <= w_res_time;
                ST_PEAK2:  r_peak <= (w_peak_cand > W'(w_vm)) ? W'(w_vm) : w_peak_cand;
                ST_TK4: begin
                    if (w_ph_acc) begin
                        r_trav  <= (w_acc_sum > (W+2)'(MAG_MAX)) ? MAG_MAX : w_acc_sum[W-1:0];
                        r_speed <= (w_spd_sum > (W+1)'(MAG_MAX)) ? MAG_MAX : w_spd_sum[W-1:0];
                    end else begin
                        r_trav <= (w_cru_sum > (W+1)'(MAG_MAX)) ? MAG_MAX : w_cru_sum[W-1:0];
                        if (w_ph_cru) r_speed <= r_peak;
                        else r_speed <= (r_speed > r_dv) ? (r_speed - r_dv) : '0;
                    end
                end
                ST_TK5: begin
                    if (w_end) begin
                        r_trav  <= r_goal;
                        r_speed <= '0;
                        r_fin   <= 1'b1;
                    end
                    r_elapsed <= w_el_sum[W] ? TIME_MAX : w_el_sum[W-1:0];
                end
                default: ;
            endcase
        end
    end

    // scratch registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SACC_WT && w_it_done) r_sacc <= w_res_mag;
        if (r_state == ST_TK1) r_dtsq <= r_prod[2*TB-1:0];
        if (r_state == ST_TK2) r_dv   <= W'(r_prod >> TB);
        if (r_state == ST_TK3) r_acc  <= W'(r_prod >> (2*TB + 1));
    end

    // output register
    logic w_load;
    assign w_load = (r_state == ST_OUT) && (!r_ov || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.position <= r_rev ? -r_trav : r_trav;
            r_out.velocity <= r_rev ? -r_speed : r_speed;
            r_out.done_res <= r_fin;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

// File: hw/rtl/tmprof_iter.sv
// ----------------------------------------------------------------------------
// Shared divide / square-root unit
// Restoring divider (one quotient bit per cycle) and digit-by-digit root
// (one root bit per cycle), sharing one remainder register and subtractor.
// ----------------------------------------------------------------------------
module tmprof_iter #(
    parameter int OPW = 64,
    parameter int DVW = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_sqrt,
    input  logic [OPW-1:0] i_opa,
    input  logic [DVW-1:0] i_opb,
    output logic           o_done,
    output logic [OPW-1:0] o_result
);
    localparam int RW = OPW/2 + 3;
    localparam int CW = $clog2(OPW + 1);
    localparam logic [CW-1:0] DIV_STEPS = CW'(OPW);
    localparam logic [CW-1:0] SQ_STEPS  = CW'(OPW/2);

    logic           r_busy, r_done, r_sqrt;
    logic [CW-1:0]  r_cnt;
    logic [OPW-1:0] r_x, r_q;
    logic [RW-1:0]  r_rem;
    logic [DVW-1:0] r_b;

    logic [RW-1:0] w_sh, w_trial;
    logic          w_ge;

    always_comb begin
        if (r_sqrt) begin
            w_sh    = {r_rem[RW-3:0], r_x[OPW-1:OPW-2]};
            w_trial = {r_q[RW-3:0], 2'b01};
        end else begin
            w_sh    = {r_rem[RW-2:0], r_x[OPW-1]};
            w_trial = RW'(r_b);
        end
        w_ge = (w_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_sqrt ? SQ_STEPS : DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sqrt <= i_sqrt;
            r_x    <= i_opa;
            r_b    <= i_opb;
            r_rem  <= '0;
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - w_trial) : w_sh;
            r_q   <= {r_q[OPW-2:0], w_ge};
            r_x   <= r_sqrt ? {r_x[OPW-3:0], 2'b00} : {r_x[OPW-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_q;

endmodule

// File: tb/sv/trapezoidal_move_profile_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoidal move profile testbench
// Drives set-target and tick requests with random gaps and output stalls,
// predicts each result from a bit-exact fixed-point profile planner, and
// compares every field in order. Config is reprogrammed between phases.
// ----------------------------------------------------------------------------
module trapezoidal_move_profile_tb;

    localparam longint unsigned VAL_MASK = 64'hFFFF_FFFF;
    localparam longint unsigned MAG_MAX  = 64'h7FFF_FFFF;
    localparam longint unsigned TIME_MAX = 64'hFFFF_FFFF;
    localparam int              FRAC     = tmprof_pkg::FRACTION_BITS_DEF;
    localparam int              TBITS    = tmprof_pkg::TICK_BITS;

    // Profile predictor plus the queue of results still owed by the block.
    class profile_scoreboard;
        longint unsigned vel_limit, acc_limit, tick_len;
        longint unsigned travelled, speed, elapsed, ramp, cruise, peak, goal;
        bit              finished, reverse;
        tmprof_pkg::t_out_item owed_q[$];
        int              errors, checked, set_count, done_count;

        function new();
            vel_limit = 65536;
            acc_limit = 65536;
            tick_len  = 66;
            travelled = 0; speed = 0; elapsed = 0;
            ramp = 0; cruise = 0; peak = 0; goal = 0;
            finished = 0; reverse = 0;
            errors = 0; checked = 0; set_count = 0; done_count = 0;
        endfunction

        function longint unsigned clip(longint unsigned x, longint unsigned lim);
            return (x > lim) ? lim : x;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void write_reg(logic [tmprof_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                tmprof_pkg::CFG_MAX_VEL:  vel_limit = longint'(data) & MAG_MAX;
                tmprof_pkg::CFG_MAX_ACC:  acc_limit = longint'(data) & MAG_MAX;
                tmprof_pkg::CFG_TICK_PER: tick_len  = longint'(data) & 64'hFFFF;
                default: ;
            endcase
        endfunction

        function void plan_move(logic [31:0] raw);
            longint unsigned vm, am, d, ramp_dist, q;
            vm = (vel_limit == 0) ? 1 : vel_limit;
            am = (acc_limit == 0) ? 1 : acc_limit;
            reverse = raw[31];
            d = reverse ? ((64'd0 - longint'(raw)) & VAL_MASK) : longint'(raw);
            goal = clip(d, MAG_MAX);
            d = goal;
            travelled = 0; speed = 0; elapsed = 0;
            finished = 0;
            ramp = clip((vm << FRAC) / am, TIME_MAX);
            ramp_dist = clip((vm * vm) / (2 * am), MAG_MAX);
            if (d > 2 * ramp_dist) begin
                cruise = clip(((d - 2 * ramp_dist) << FRAC) / vm, TIME_MAX);
                peak = vm;
            end else begin
                // too short to cruise: triangle, peak capped at vmax
                q = (d << FRAC) / am;
                ramp = clip(floor_sqrt(q << FRAC), TIME_MAX);
                peak = clip((am * ramp) >> FRAC, vm);
                cruise = 0;
            end
        endfunction

        function void step_tick();
            longint unsigned am, dt, dv, ds;
            am = (acc_limit == 0) ? 1 : acc_limit;
            dt = tick_len;
            dv = (am * dt) >> TBITS;
            if (finished) return;
            if (elapsed < ramp) begin
                ds = ((speed * dt) >> TBITS) + ((am * dt * dt) >> (2 * TBITS + 1));
                travelled = clip(travelled + ds, MAG_MAX);
                speed = clip(speed + dv, MAG_MAX);
            end else if (elapsed < ramp + cruise) begin
                speed = peak;
                travelled = clip(travelled + ((peak * dt) >> TBITS), MAG_MAX);
            end else begin
                travelled = clip(travelled + ((speed * dt) >> TBITS), MAG_MAX);
                speed = (speed > dv) ? speed - dv : 0;
            end
            if (travelled >= goal || elapsed > 2 * ramp + cruise) begin
                travelled = goal;
                speed = 0;
                elapsed = 0;
                finished = 1;
            end
            elapsed = clip(elapsed + dt, TIME_MAX);
        endfunction

        function logic [31:0] apply_sign(longint unsigned mag);
            return reverse ? 32'(64'd0 - mag) : 32'(mag);
        endfunction

        function void note_request(tmprof_pkg::t_in_item req);
            tmprof_pkg::t_out_item res;
            if (req.operation == tmprof_pkg::OP_SET_TARGET) begin
                plan_move(req.target_distance);
                set_count++;
            end else begin
                step_tick();
            end
            res.position = apply_sign(travelled);
            res.velocity = apply_sign(speed);
            res.done_res = finished;
            owed_q.push_back(res);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(tmprof_pkg::t_out_item got);
            tmprof_pkg::t_out_item want;
            if (owed_q.size() == 0) begin
                report("result with nothing outstanding");
                return;
            end
            want = owed_q.pop_front();
            checked++;
            if (got.done_res) done_count++;
            if (got.position !== want.position)
                report($sformatf("position got %h want %h", got.position, want.position));
            if (got.velocity !== want.velocity)
                report($sformatf("velocity got %h want %h", got.velocity, want.velocity));
            if (got.done_res !== want.done_res)
                report($sformatf("done got %b want %b", got.done_res, want.done_res));
        endtask

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    tmprof_pkg::t_in_item                i_in_data;
    logic                                o_out_valid;
    logic                                i_out_stall;
    tmprof_pkg::t_out_item               o_out_data;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [tmprof_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [31:0]                         i_cfg_data;

    profile_scoreboard     sb;
    bit                    calm;   // no gaps, no stalls while set

    trapezoidal_move_profile dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Mostly short idle stretches, now and then a long one.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    // Output side: random stalls, sampled results are checked in order.
    initial begin : out_side
        int hold;
        hold = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                hold = pick_gap();
                i_out_stall <= (hold > 0);
                if (hold > 0) hold--;
            end
        end
    end

    // One request; valid stays high into the next request when no gap follows.
    task send(logic op, logic [31:0] target);
        tmprof_pkg::t_in_item req;
        int gap;
        req.operation = op;
        req.target_distance = target;
        i_in_data  <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task send_tick();
        send(tmprof_pkg::OP_TICK, $urandom);
    endtask

    // Wait out every outstanding result, then let the block settle.
    task drain();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task cfg_write(logic [tmprof_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task program_regs(logic [31:0] vel, logic [31:0] acc, logic [31:0] per);
        drain();
        cfg_write(tmprof_pkg::CFG_MAX_VEL, vel);
        cfg_write(tmprof_pkg::CFG_MAX_ACC, acc);
        cfg_write(tmprof_pkg::CFG_TICK_PER, per);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [31:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return 32'd1;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(32'h4000, 32'h8_0000);
        endcase
    endfunction

    function logic [31:0] pick_distance();
        logic [31:0] d;
        case ($urandom_range(0, 5))
            0:       d = $urandom;
            1:       d = $urandom_range(1, 32'h100);
            default: d = $urandom_range(32'h1000, 32'h8_0000);
        endcase
        if ($urandom_range(0, 1)) d = -d;
        return d;
    endfunction

    initial begin : stim
        int sent, per;
        sb = new();
        calm = 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, tick before any target finishes at once,
        // both target extremes, zero target.
        send_tick();
        send_tick();
        send(tmprof_pkg::OP_SET_TARGET, 32'h7FFF_FFFF);
        send_tick();
        send_tick();
        send(tmprof_pkg::OP_SET_TARGET, 32'h8000_0000);
        send_tick();
        send(tmprof_pkg::OP_SET_TARGET, 32'h0);
        send_tick();

        // Long ticks, short move: reaches the goal, then ticks past the finish.
        program_regs(32'h1_0000, 32'h4_0000, 32'd65535);
        send(tmprof_pkg::OP_SET_TARGET, 32'h1_0000);
        repeat (4) send_tick();
        send(tmprof_pkg::OP_SET_TARGET, -32'sh3_0000);
        repeat (5) send_tick();

        // Zero registers act as the smallest step; zero tick freezes time.
        program_regs(32'h0, 32'h0, 32'h0);
        send(tmprof_pkg::OP_SET_TARGET, 32'h100);
        send_tick();
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(tmprof_pkg::OP_SET_TARGET, 32'h7FFF_FFFF);
        send_tick();
        send_tick();

        // Random phases: plan a move, tick it, sometimes past the finish.
        sent = 0;
        for (int ph = 0; ph < 9; ph++) begin
            case ($urandom_range(0, 3))
                0:       per = 1;
                1:       per = 65535;
                default: per = $urandom_range(2000, 65535);
            endcase
            if (ph == 0) per = 1;
            if (ph == 1) per = 65535;
            program_regs(pick_rate(), pick_rate(),
                         {1'($urandom_range(0, 1)), 15'd0, per[15:0]});
            calm = (ph % 3 == 2);
            while (sent < (ph + 1) * 105) begin
                if ($urandom_range(0, 39) == 0) drain();
                if ($urandom_range(0, 9) == 0) begin
                    send(tmprof_pkg::OP_SET_TARGET, $urandom);   // broken sequence
                    sent++;
                end
                send(tmprof_pkg::OP_SET_TARGET, pick_distance());
                sent++;
                repeat ($urandom_range(0, 30)) begin
                    send_tick();
                    sent++;
                end
            end
        end
        calm = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);

        $display("tb: %0d results checked, %0d moves planned, %0d finished results",
                 sb.checked, sb.set_count, sb.done_count);
        $display("tb: config extremes, zero registers and random stall patterns covered");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #30ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tmprof_pkg.sv
hw/rtl/tmprof_iter.sv
hw/rtl/trapezoidal_move_profile.sv
tb/sv/trapezoidal_move_profile_tb.sv
